/* rtl/arrstat_pkg.sv */
package arrstat_pkg;

  localparam int SMP_W       = 16;
  localparam int MAX_SAMPLES = 1024;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int OUT_CNT_W   = 11;
  localparam int SUM_W       = SMP_W + CNT_W;
  localparam int MAG_W       = SUM_W - 1;
  localparam int SSQ_W       = 2 * SMP_W - 2 + CNT_W;
  localparam int PROD_W      = CNT_W + SSQ_W;
  localparam int NN_W        = 2 * CNT_W;
  localparam int FRAC_W      = 8;
  localparam int DVS_W       = NN_W;
  localparam int DVD_W       = PROD_W + 2 * FRAC_W;
  localparam int OUT_W       = 24;
  localparam int SQ_IN_W     = 48;
  localparam int RT_W        = SQ_IN_W / 2;
  localparam int SREM_W      = RT_W + 2;
  localparam int STEP_W      = $clog2(DVD_W);

  localparam logic [OUT_W-1:0] MEAN_POS_MAX = 24'h7F_FFFF;
  localparam logic [OUT_W-1:0] MEAN_NEG_MIN = 24'h80_0000;
  localparam logic [OUT_W-1:0] SD_MAX       = 24'hFF_FFFF;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_MUL,
    ST_MEAN_LD,
    ST_MEAN_DIV,
    ST_MEAN_END,
    ST_VAR_LD,
    ST_VAR_DIV,
    ST_SQRT_LD,
    ST_SQRT,
    ST_SQRT_END,
    ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic acc;
    logic mul;
    logic mean_ld;
    logic var_ld;
    logic div_step;
    logic mean_end;
    logic sqrt_ld;
    logic sqrt_step;
    logic sqrt_end;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic few;
  } dp_status_t;

endpackage

/* rtl/arrstat_in_if.sv */
interface arrstat_in_if import arrstat_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    last;

  modport source (output valid, output sample, output last, input ready);
  modport sink (input valid, input sample, input last, output ready);
endinterface

/* rtl/arrstat_out_if.sv */
interface arrstat_out_if import arrstat_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SMP_W-1:0]     max_value;
  logic signed [SMP_W-1:0]     min_value;
  logic signed [OUT_W-1:0]     mean_value;
  logic        [OUT_W-1:0]     std_dev;
  logic        [OUT_CNT_W-1:0] sample_count;
  logic                        too_few;

  modport source (output valid, output max_value, output min_value, output mean_value,
                  output std_dev, output sample_count, output too_few, input ready);
  modport sink (input valid, input max_value, input min_value, input mean_value,
                input std_dev, input sample_count, input too_few, output ready);
endinterface

/* rtl/array_statistics_core.sv */
// running statistics over sets of signed 16-bit samples
// in_ch carries one sample per word with a last flag; a word is taken when
// valid and ready are both high. out_ch carries one result word per set:
// max, min, mean (signed 16.8), sample std deviation with divisor n-1
// (unsigned 16.8), the sample count and a flag for a one-sample set.
// samples of a set are taken one per cycle. after the last word the input
// stalls while the result is worked out: a multiply step, a serial
// restoring division for the mean, a second division on the same divider
// for the variance and a bit-serial square root; a one-sample set skips
// the variance and the square root before out valid.
// samples beyond 1024 in one set are ignored, but their last flag still
// closes the set. the result sits in an output register until taken; the
// next set is accepted meanwhile, and only its completion waits for a
// stalled receiver. synchronous reset clears the accumulators and drops
// out valid; the block is ready for samples in the first cycle after it.
module array_statistics_core import arrstat_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  arrstat_in_if.sink  in_ch,
  arrstat_out_if.source out_ch
);

  dp_cmd_t    cmd;
  dp_status_t status;

  arrstat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  arrstat_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_sample (in_ch.sample),
    .o_max     (out_ch.max_value),
    .o_min     (out_ch.min_value),
    .o_mean    (out_ch.mean_value),
    .o_sd      (out_ch.std_dev),
    .o_count   (out_ch.sample_count),
    .o_few     (out_ch.too_few)
  );

endmodule

/* rtl/arrstat_ctrl.sv */
module arrstat_ctrl import arrstat_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t       state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_ACC:      if (in_valid && in_last) state_nxt = ST_MUL;
      ST_MUL:      state_nxt = ST_MEAN_LD;
      ST_MEAN_LD:  state_nxt = ST_MEAN_DIV;
      ST_MEAN_DIV: if (step_r == '0) state_nxt = ST_MEAN_END;
      ST_MEAN_END: state_nxt = status.few ? ST_FIN : ST_VAR_LD;
      ST_VAR_LD:   state_nxt = ST_VAR_DIV;
      ST_VAR_DIV:  if (step_r == '0) state_nxt = ST_SQRT_LD;
      ST_SQRT_LD:  state_nxt = ST_SQRT;
      ST_SQRT:     if (step_r == '0) state_nxt = ST_SQRT_END;
      ST_SQRT_END: state_nxt = ST_FIN;
      ST_FIN:      if (slot_free) state_nxt = ST_ACC;
      default:     state_nxt = ST_ACC;
    endcase
  end

  // iteration counter for the divider and square root loops
  always_comb begin
    step_nxt = step_r;
    unique case (state_r) inside
      ST_MEAN_LD, ST_VAR_LD:   step_nxt = STEP_W'(DVD_W - 1);
      ST_SQRT_LD:              step_nxt = STEP_W'(RT_W - 1);
      ST_MEAN_DIV, ST_VAR_DIV,
      ST_SQRT:                 step_nxt = step_r - 1'b1;
      default:                 step_nxt = step_r;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_ACC: begin
        in_ready = 1'b1;
        cmd.acc  = in_valid;
      end
      ST_MUL:      cmd.mul       = 1'b1;
      ST_MEAN_LD:  cmd.mean_ld   = 1'b1;
      ST_MEAN_DIV: cmd.div_step  = 1'b1;
      ST_MEAN_END: cmd.mean_end  = 1'b1;
      ST_VAR_LD:   cmd.var_ld    = 1'b1;
      ST_VAR_DIV:  cmd.div_step  = 1'b1;
      ST_SQRT_LD:  cmd.sqrt_ld   = 1'b1;
      ST_SQRT:     cmd.sqrt_step = 1'b1;
      ST_SQRT_END: cmd.sqrt_end  = 1'b1;
      ST_FIN: begin
        if (slot_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/arrstat_dp.sv */
module arrstat_dp import arrstat_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dp_cmd_t                     cmd,
  output dp_status_t                  status,
  input  logic signed [SMP_W-1:0]     in_sample,
  output logic signed [SMP_W-1:0]     o_max,
  output logic signed [SMP_W-1:0]     o_min,
  output logic signed [OUT_W-1:0]     o_mean,
  output logic        [OUT_W-1:0]     o_sd,
  output logic        [OUT_CNT_W-1:0] o_count,
  output logic                        o_few
);

  // accumulators
  logic signed [SMP_W-1:0] max_r, min_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SSQ_W-1:0]        ssq_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [2*SMP_W-1:0] sq_prod;
  logic                    room;

  // finishing arithmetic
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [PROD_W-1:0] sqm_r, sqm_nxt;
  logic [NN_W-1:0]   nn1_r, nn1_nxt;
  logic [PROD_W-1:0] diff;

  // shared restoring divider
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] dq_r;
  logic [DVS_W:0]   dtrial;
  logic             dge;

  // bit-serial square root
  logic [SQ_IN_W-1:0] sv_r;
  logic [RT_W-1:0]    root_r;
  logic [SREM_W-1:0]  srem_r;
  logic [SREM_W+1:0]  strial, stest;
  logic               sge;
  logic [RT_W:0]      root_rnd;

  logic [OUT_W-1:0] mean_r, mean_nxt;
  logic [OUT_W-1:0] sd_r;

  assign room    = cnt_r < CNT_W'(MAX_SAMPLES);
  assign sq_prod = in_sample * in_sample;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.finish) begin
      max_r <= {1'b1, {(SMP_W-1){1'b0}}};
      min_r <= {1'b0, {(SMP_W-1){1'b1}}};
      sum_r <= '0;
      ssq_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc && room) begin
      if (in_sample > max_r) max_r <= in_sample;
      if (in_sample < min_r) min_r <= in_sample;
      sum_r <= sum_r + SUM_W'(in_sample);
      ssq_r <= ssq_r + SSQ_W'($unsigned(sq_prod));
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign status.few = (cnt_r == CNT_W'(1));

  assign mag      = sum_r[SUM_W-1] ? MAG_W'(-sum_r) : MAG_W'(sum_r);
  assign prod_nxt = cnt_r * ssq_r;
  assign sqm_nxt  = mag * mag;
  assign nn1_nxt  = cnt_r * (cnt_r - 1'b1);
  assign diff     = prod_r - sqm_r;

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= prod_nxt;
      sqm_r  <= sqm_nxt;
      nn1_r  <= nn1_nxt;
    end
  end

  // one quotient bit per cycle, quotient shifts into the dividend register
  assign dtrial = {rem_r, dq_r[DVD_W-1]};
  assign dge    = dtrial >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.mean_ld) begin
      // round to nearest: (2*mag*256 + n) / (2*n)
      dq_r  <= DVD_W'({mag, 1'b0, {FRAC_W{1'b0}}}) + DVD_W'(cnt_r);
      dvs_r <= DVS_W'({cnt_r, 1'b0});
      rem_r <= '0;
    end else if (cmd.var_ld) begin
      dq_r  <= {diff, {(2*FRAC_W){1'b0}}};
      dvs_r <= nn1_r;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= dge ? DVS_W'(dtrial - {1'b0, dvs_r}) : dtrial[DVS_W-1:0];
      dq_r  <= {dq_r[DVD_W-2:0], dge};
    end
  end

  always_comb begin
    if (sum_r[SUM_W-1]) begin
      mean_nxt = (dq_r > DVD_W'(MEAN_NEG_MIN)) ? MEAN_NEG_MIN : OUT_W'(-dq_r);
    end else begin
      mean_nxt = (dq_r > DVD_W'(MEAN_POS_MAX)) ? MEAN_POS_MAX : dq_r[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mean_end) mean_r <= mean_nxt;
  end

  assign strial = {srem_r, sv_r[SQ_IN_W-1 -: 2]};
  assign stest  = (SREM_W+2)'({root_r, 2'b01});
  assign sge    = strial >= stest;

  // remainder is value minus root squared, so rounding is a single compare
  assign root_rnd = (srem_r > SREM_W'(root_r)) ? {1'b0, root_r} + 1'b1 : {1'b0, root_r};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_ld) begin
      sv_r   <= dq_r[SQ_IN_W-1:0];
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.sqrt_step) begin
      sv_r   <= {sv_r[SQ_IN_W-3:0], 2'b00};
      srem_r <= sge ? SREM_W'(strial - stest) : SREM_W'(strial);
      root_r <= {root_r[RT_W-2:0], sge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sqrt_end) sd_r <= root_rnd[RT_W] ? SD_MAX : root_rnd[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      o_max   <= max_r;
      o_min   <= min_r;
      o_mean  <= mean_r;
      o_sd    <= status.few ? '0 : sd_r;
      o_count <= OUT_CNT_W'(cnt_r);
      o_few   <= status.few;
    end
  end

endmodule

/* verif/array_statistics_core_test.sv */
`timescale 1ns / 100ps

module array_statistics_core_test;
  import arrstat_pkg::*;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic                    last;
  } sample_word_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] max_value;
    logic signed [SMP_W-1:0] min_value;
    logic signed [OUT_W-1:0] mean_value;
    logic [OUT_W-1:0]        std_dev;
    logic [OUT_CNT_W-1:0]    sample_count;
    logic                    too_few;
  } set_stats_t;

  localparam int DIR_WORDS = 25;
  localparam int DIR_SAMPLE [DIR_WORDS] = '{
    32767, -32768, 0, -32768, 32767, 32767, 32767, -32768, -32768, -32768,
    -1, -2, -2, 1, 2, 2, -32768, 32767, -32768, 32767, 5, -7, 100, -3, 0};
  localparam bit DIR_LAST [DIR_WORDS] = '{
    1, 1, 1, 0, 1, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 1};

  logic clk;
  logic rst_n;

  arrstat_in_if  in_ch ();
  arrstat_out_if out_ch ();

  array_statistics_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_word_t pending_q[$];
  set_stats_t   expected_stats_q[$];

  // running statistics of the set being collected
  int              set_max;
  int              set_min;
  longint          set_sum;
  longint unsigned set_sum_sq;
  int unsigned     set_count;

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  in_word_taken;
  int  errors;
  int  words_queued;
  int  words_taken;
  int  sets_checked;
  int  single_sets;
  int  capped_sets;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void clear_set_stats();
    set_max    = -32768;
    set_min    = 32767;
    set_sum    = 0;
    set_sum_sq = 0;
    set_count  = 0;
  endfunction

  // fold one accepted word into the running statistics, close the set on last
  function automatic void absorb_sample(input logic signed [SMP_W-1:0] smp, input logic last);
    int              sv;
    longint unsigned n;
    longint unsigned mag;
    longint unsigned mq;
    longint unsigned d;
    longint unsigned m;
    longint unsigned q;
    longint unsigned r;
    longint unsigned big;
    longint unsigned root;
    longint unsigned rem;
    longint unsigned one_bit;
    longint          mean;
    set_stats_t      res;
    sv = smp;
    if (set_count < MAX_SAMPLES) begin
      if (sv > set_max) set_max = sv;
      if (sv < set_min) set_min = sv;
      set_sum    += sv;
      set_sum_sq += longint'(sv) * longint'(sv);
      set_count++;
    end
    if (!last) return;
    n   = set_count;
    mag = (set_sum < 0) ? -set_sum : set_sum;
    // mean rounded to nearest, ties away from zero
    mq   = (2 * (mag << 8) + n) / (2 * n);
    mean = (set_sum < 0) ? -longint'(mq) : longint'(mq);
    if (mean > 8388607) mean = 8388607;
    if (mean < -8388608) mean = -8388608;
    res = '0;
    res.max_value    = set_max;
    res.min_value    = set_min;
    res.mean_value   = mean;
    res.sample_count = n;
    res.too_few      = (n == 1);
    if (n != 1) begin
      d   = n * set_sum_sq - mag * mag;
      m   = n * (n - 1);
      q   = d / m;
      r   = d % m;
      big = (q << 16) + (r << 16) / m;
      // integer square root, then round to nearest
      root    = 0;
      rem     = big;
      one_bit = 64'd1 << 62;
      while (one_bit > rem) one_bit >>= 2;
      while (one_bit != 0) begin
        if (rem >= root + one_bit) begin
          rem  -= root + one_bit;
          root  = (root >> 1) + one_bit;
        end else begin
          root >>= 1;
        end
        one_bit >>= 2;
      end
      if (big - root * root > root) root++;
      res.std_dev = (root > 64'hFF_FFFF) ? SD_MAX : root;
    end
    expected_stats_q.push_back(res);
    clear_set_stats();
  endfunction

  function automatic void check_stats();
    set_stats_t want;
    if (expected_stats_q.size() == 0) begin
      $error("result word with no set waiting for it");
      errors++;
      return;
    end
    want = expected_stats_q.pop_front();
    sets_checked++;
    if (want.too_few) single_sets++;
    if (want.sample_count == MAX_SAMPLES) capped_sets++;
    if (out_ch.max_value !== want.max_value) begin
      $error("max_value: expected %0d, got %0d", want.max_value, out_ch.max_value);
      errors++;
    end
    if (out_ch.min_value !== want.min_value) begin
      $error("min_value: expected %0d, got %0d", want.min_value, out_ch.min_value);
      errors++;
    end
    if (out_ch.mean_value !== want.mean_value) begin
      $error("mean_value: expected %0d, got %0d", want.mean_value, out_ch.mean_value);
      errors++;
    end
    if (out_ch.std_dev !== want.std_dev) begin
      $error("std_dev: expected %0d, got %0d", want.std_dev, out_ch.std_dev);
      errors++;
    end
    if (out_ch.sample_count !== want.sample_count) begin
      $error("sample_count: expected %0d, got %0d", want.sample_count, out_ch.sample_count);
      errors++;
    end
    if (out_ch.too_few !== want.too_few) begin
      $error("too_few: expected %0d, got %0d", want.too_few, out_ch.too_few);
      errors++;
    end
  endfunction

  // monitor: sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_word_taken = 1'b1;
        words_taken++;
        absorb_sample(in_ch.sample, in_ch.last);
      end
      if (out_ch.valid && out_ch.ready) check_stats();
    end
  end

  // driver: change inputs at the falling edge
  always @(negedge clk) begin
    sample_word_t w;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_word_taken) begin
        in_word_taken = 1'b0;
        if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_q.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.sample <= w.sample;
          in_ch.last   <= w.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void queue_word(input int smp, input bit last);
    sample_word_t w;
    w.sample = smp;
    w.last   = last;
    pending_q.push_back(w);
    words_queued++;
  endfunction

  function automatic int clamp_sample(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // one set of random length and content: full range, clustered, constant or extremes
  function automatic void queue_random_set();
    int len;
    int style;
    int base;
    int smp;
    len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
    style = $urandom_range(3);
    base  = int'($urandom_range(65535)) - 32768;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: smp = int'($urandom_range(65535)) - 32768;
        1: smp = clamp_sample(base + int'($urandom_range(40)) - 20);
        2: smp = base;
        default: smp = $urandom_range(1) ? 32767 : -32768;
      endcase
      queue_word(smp, i == len - 1);
    end
  endfunction

  task automatic queue_random_sets(input int budget);
    int start;
    start = words_queued;
    while (words_queued - start < budget) queue_random_set();
  endtask

  // hold the sender until every queued word is in and every set has reported
  task automatic wait_drained();
    while (pending_q.size() != 0 || in_ch.valid || expected_stats_q.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    errors       = 0;
    words_queued = 0;
    words_taken  = 0;
    sets_checked = 0;
    single_sets  = 0;
    capped_sets  = 0;
    in_word_taken = 1'b0;
    clear_set_stats();
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 80;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_WORDS; i++) queue_word(DIR_SAMPLE[i], DIR_LAST[i]);
    queue_random_sets(300);
    wait_drained();

    send_idle_pct = 80;
    recv_idle_pct = 35;
    // one set running past the count bound; the words beyond it must be ignored
    for (int i = 0; i < MAX_SAMPLES; i++)
      queue_word(int'($urandom_range(4000)) - 2000, 1'b0);
    queue_word(32767, 1'b0);
    queue_word(-32768, 1'b0);
    queue_word(int'($urandom_range(65535)) - 32768, 1'b1);
    queue_random_sets(100);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_sets(200);
    wait_drained();
    repeat (200) @(posedge clk);

    $display("covered %0d sample words, %0d sets checked (%0d single-sample, %0d at the count bound)",
             words_taken, sets_checked, single_sets, capped_sets);
    $display("three idle profiles on sender and receiver, with a full drain between them");
    if (errors == 0) begin
      $display("PASS array_statistics_core");
    end else begin
      $display("FAIL array_statistics_core");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL array_statistics_core");
    $finish;
  end

endmodule
